// File: rtl/sbl_pkg.sv
// Shared types and constants for the sorted byte list core.
`timescale 1ns / 1ps

package sbl_pkg;

    // List geometry
    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int VAL_W      = 8;
    localparam int OP_W       = 2;
    localparam int STS_W      = 2;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_APPEND = 2'd2,
        OP_POP    = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [STS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // latch a new operation
        logic rd;     // issue a read of the current entry
        logic eval;   // act on the read data
        logic tail;   // write the carried byte at the tail
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic last;       // current entry is the last one held
        logic op_insert;  // latched operation is a sorted insert
    } t_dp_sts;

endpackage

// File: rtl/sbl_ctrl.sv
// Controller state machine for the sorted byte list core.
`timescale 1ns / 1ps

module sbl_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic [sbl_pkg::OP_W-1:0] i_operation,
    input  sbl_pkg::t_dp_sts         i_sts,
    output sbl_pkg::t_dp_cmd         o_cmd,
    output logic                     busy,
    output logic                     o_done
);
    import sbl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EVAL = 5'b00100,
        S_TAIL = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (t_op'(i_operation))
                        OP_INSERT: n_state = i_sts.full  ? S_RESP :
                                             i_sts.empty ? S_TAIL : S_READ;
                        OP_APPEND: n_state = i_sts.full  ? S_RESP : S_TAIL;
                        OP_REMOVE,
                        OP_POP:    n_state = i_sts.empty ? S_RESP : S_READ;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (i_sts.last) begin
                    n_state = i_sts.op_insert ? S_TAIL : S_RESP;
                end else begin
                    n_state = S_READ;
                end
            end
            S_TAIL:  n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode commands and handshake outputs
    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && start;
        o_cmd.rd   = (r_state == S_READ);
        o_cmd.eval = (r_state == S_EVAL);
        o_cmd.tail = (r_state == S_TAIL);
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);

endmodule

// File: rtl/sbl_dpath.sv
// Datapath for the sorted byte list core: entry memory, walk index and result registers.
`timescale 1ns / 1ps

module sbl_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sbl_pkg::t_dp_cmd          i_cmd,
    input  logic [sbl_pkg::OP_W-1:0]  i_operation,
    input  logic [sbl_pkg::VAL_W-1:0] i_value,
    output sbl_pkg::t_dp_sts          o_sts,
    output logic [sbl_pkg::STS_W-1:0] o_status,
    output logic [sbl_pkg::VAL_W-1:0] o_popped_value,
    output logic [sbl_pkg::CNT_W-1:0] o_entry_count
);
    import sbl_pkg::*;

    // Entry memory
    logic [VAL_W-1:0] r_mem [LIST_DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // Walk and operation registers
    t_op              r_op;
    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] r_carry;
    logic [VAL_W-1:0] n_carry;
    logic [IDX_W-1:0] r_idx;
    logic             r_found;
    logic [CNT_W-1:0] r_count;
    t_status          r_status;
    logic [VAL_W-1:0] r_popped;

    logic             full;
    logic             empty;
    logic             last;
    logic             hit;
    logic             match;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    t_status          load_status;

    assign full  = (r_count == CNT_W'(LIST_DEPTH));
    assign empty = (r_count == '0);
    assign last  = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));

    assign o_sts.full      = full;
    assign o_sts.empty     = empty;
    assign o_sts.last      = last;
    assign o_sts.op_insert = (r_op == OP_INSERT);

    // Reject a new operation that cannot proceed
    always_comb begin
        load_status = ST_OK;
        unique case (t_op'(i_operation))
            OP_INSERT, OP_APPEND: if (full)  load_status = ST_FULL;
            OP_REMOVE, OP_POP:    if (empty) load_status = ST_EMPTY;
            default:              load_status = ST_OK;
        endcase
    end

    // Evaluate the entry just read; pick the memory write
    always_comb begin
        match   = (r_op == OP_POP) ? (r_idx == '0) : (r_rdata == r_val);
        hit     = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_carry;
        n_carry = r_carry;
        if (i_cmd.tail) begin
            wr_en   = 1'b1;
            wr_addr = r_count[IDX_W-1:0];
            wr_data = r_carry;
        end else if (i_cmd.eval) begin
            if (r_op == OP_INSERT) begin
                // Shift the rest up from the first larger entry on
                hit     = r_found || (r_rdata > r_val);
                wr_en   = hit;
                wr_addr = r_idx;
                wr_data = r_carry;
                if (hit) begin
                    n_carry = r_rdata;
                end
            end else begin
                // Close the gap behind the removed entry
                hit     = r_found || match;
                wr_en   = r_found;
                wr_addr = r_idx - IDX_W'(1);
                wr_data = r_rdata;
            end
        end
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_operation);
            r_val    <= i_value;
            r_carry  <= i_value;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_popped <= '0;
            r_status <= load_status;
        end else if (i_cmd.eval) begin
            r_carry <= n_carry;
            r_found <= hit;
            r_idx   <= r_idx + IDX_W'(1);
            if ((r_op == OP_POP) && !r_found) begin
                r_popped <= r_rdata;
            end
            if (last && (r_op != OP_INSERT) && !hit) begin
                r_status <= ST_NOT_FOUND;
            end
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.tail) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.eval && last && (r_op != OP_INSERT) && hit) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_entry_count  = r_count;

endmodule

// File: rtl/sorted_byte_list_core.sv
// Top level of the sorted byte list core: controller plus datapath.
`timescale 1ns / 1ps
//
// Holds up to 16 bytes and runs one operation per command: sorted insert,
// remove by key, append at tail, or pop front.
// Command channel: a transfer happens at a rising edge with start high and
// busy low; i_operation and i_value are sampled at that edge. busy stays
// high until the result has been shown.
// Result channel: o_done is high for exactly one cycle; o_status,
// o_popped_value and o_entry_count are valid in that cycle. The receiver
// cannot stall; the result is taken at the edge that ends the cycle.
// Steps from the accepting edge to the result cycle: a rejected operation
// (full or empty) goes straight to the result; an append, or an insert
// into an empty list, writes the tail entry first; an insert, remove or
// pop walks the whole list, and an insert then ends with the tail write.
// One item is worked at a time; the walk reads each entry (S_READ), then
// compares it and does the shift write (S_EVAL), as the entry memory has
// a single registered read port.
// Synchronous reset clears the entry count and returns to idle; the entry
// memory is not cleared, as entries are read only after being written.
//
module sorted_byte_list_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [sbl_pkg::OP_W-1:0]  i_operation,
    input  logic [sbl_pkg::VAL_W-1:0] i_value,
    output logic                      o_done,
    output logic [sbl_pkg::STS_W-1:0] o_status,
    output logic [sbl_pkg::VAL_W-1:0] o_popped_value,
    output logic [sbl_pkg::CNT_W-1:0] o_entry_count
);
    import sbl_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    sbl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .busy        (busy),
        .o_done      (o_done)
    );

    sbl_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_sts          (sts),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_entry_count  (o_entry_count)
    );

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_count <= CNT_W'(LIST_DEPTH))
        else $error("entry count above list depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("not idle after result");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (o_entry_count == CNT_W'(LIST_DEPTH)))
        else $error("full status with list not full");

    a_pop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_popped_value != '0)) |-> (o_status == ST_OK))
        else $error("popped value with failing status");
`endif

endmodule
